// File: rtl/core/csiu_pkg.sv
package csiu_pkg;

   localparam int KEY_CODE_BITS_DEFAULT = 21;
   localparam int MOD_BITS = 8;
   localparam int EVENT_BITS = 4;
   localparam int DIGIT_BITS = 4;

   localparam logic [7:0] BYTE_ESC   = 8'h1B;
   localparam logic [7:0] BYTE_SEMI  = 8'h3B;
   localparam logic [7:0] BYTE_COLON = 8'h3A;
   localparam logic [7:0] BYTE_U     = 8'h75;
   localparam logic [7:0] BYTE_ZERO  = 8'h30;
   localparam logic [7:0] BYTE_NINE  = 8'h39;

   localparam logic [MOD_BITS-1:0] MOD_MAX = 8'hFF;

   typedef enum logic [4:0] {
      PH_WAIT  = 5'b00001,
      PH_SKIP  = 5'b00010,
      PH_CODE  = 5'b00100,
      PH_MOD   = 5'b01000,
      PH_EVENT = 5'b10000
   } phase_type;

   // Decoder verdict for the current beat.
   typedef struct packed {
      phase_type phase_in;
      logic      done;
      logic      show_key;
   } ctl_type;

endpackage

// File: rtl/core/csi_u_key_sequence_parser_top.sv
// Keyboard escape-sequence parser: one terminal byte in per beat, one result
// beat out per byte, one byte per clock sustained while the sink does not
// stall. The decode is a single combinational pass from the parser state and
// the incoming byte into the output register; that register holds a result
// while the sink stalls and a new byte is still taken in the cycle the held
// result is drained. rsp_tlast marks the byte that completes a sequence and
// then carries the key code, modifier and event; on the ';' ending the key
// code only the key code is shown, and all other result beats are zero.
module csi_u_key_sequence_parser_top
   import csiu_pkg::*;
#(
   parameter int KEY_CODE_BITS = KEY_CODE_BITS_DEFAULT,
   localparam int RSP_BITS = KEY_CODE_BITS + MOD_BITS + EVENT_BITS,
   localparam int RSP_TDATA_BITS = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // byte_req
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic                      rsp_tlast,   // done_res
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata    // key, modifier, event_kind
);

   localparam int MOD_LO = KEY_CODE_BITS;
   localparam int EVENT_LO = KEY_CODE_BITS + MOD_BITS;

   phase_type                 phase_ff, phase_in;
   logic [KEY_CODE_BITS-1:0]  code_ff, code_in;
   logic [MOD_BITS-1:0]       mod_ff, mod_in;
   logic [EVENT_BITS-1:0]     event_ff, event_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_last_ff;
   logic [RSP_TDATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                      req_accept;
   ctl_type                   ctl;

   csiu_decode #(
      .KEY_CODE_BITS(KEY_CODE_BITS)
   ) u_decode (
      .byte_in (req_tdata),
      .phase_ff(phase_ff),
      .code_ff (code_ff),
      .mod_ff  (mod_ff),
      .event_ff(event_ff),
      .ctl     (ctl),
      .code_in (code_in),
      .mod_in  (mod_in),
      .event_in(event_in)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign phase_in = ctl.phase_in;

   always_comb begin
      rsp_data_in = '0;
      if (ctl.done || ctl.show_key) begin
         rsp_data_in[KEY_CODE_BITS-1:0] = code_ff;
      end
      if (ctl.done) begin
         rsp_data_in[MOD_LO +: MOD_BITS] = mod_ff;
         rsp_data_in[EVENT_LO +: EVENT_BITS] = event_ff;
      end
   end

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         code_ff <= '0;
         mod_ff <= '0;
         event_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            phase_ff <= phase_in;
            code_ff <= code_in;
            mod_ff <= mod_in;
            event_ff <= event_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_last_ff <= ctl.done;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tdata = rsp_data_ff;

   // A completed sequence always returns the parser to waiting for escape.
   a_done_to_wait: assert property (@(posedge clock) disable iff (reset)
      req_accept && ctl.done |=> phase_ff == PH_WAIT)
      else $error("parser did not return to wait after a completed sequence");

   // Modifier and event are only ever shown on a completing beat.
   a_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |->
         rsp_tdata[RSP_TDATA_BITS-1:MOD_LO] == '0)
      else $error("modifier or event shown on a beat that completes nothing");

   // Draining the output register must make room for the next byte.
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("input stalled while the output register is free");

   // Accumulators are clear whenever the parser waits for escape.
   a_wait_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_WAIT |-> code_ff == '0 && mod_ff == '0 && event_ff == '0)
      else $error("accumulators not clear while waiting for escape");

endmodule

// File: rtl/core/csiu_decode.sv
module csiu_decode
   import csiu_pkg::*;
#(
   parameter int KEY_CODE_BITS = KEY_CODE_BITS_DEFAULT
) (
   input  logic [7:0]               byte_in,
   input  phase_type                phase_ff,
   input  logic [KEY_CODE_BITS-1:0] code_ff,
   input  logic [MOD_BITS-1:0]      mod_ff,
   input  logic [EVENT_BITS-1:0]    event_ff,
   output ctl_type                  ctl,
   output logic [KEY_CODE_BITS-1:0] code_in,
   output logic [MOD_BITS-1:0]      mod_in,
   output logic [EVENT_BITS-1:0]    event_in
);

   localparam int CODE_WIDE_BITS = KEY_CODE_BITS + 4;
   localparam int MOD_WIDE_BITS = MOD_BITS + 4;

   logic                      is_digit;
   logic [DIGIT_BITS-1:0]     digit;
   logic [CODE_WIDE_BITS-1:0] code_wide;
   logic [CODE_WIDE_BITS-1:0] code_ext;
   logic [MOD_WIDE_BITS-1:0]  mod_wide;
   logic [MOD_WIDE_BITS-1:0]  mod_ext;
   logic [KEY_CODE_BITS-1:0]  code_sat;
   logic [MOD_BITS-1:0]       mod_sat;

   assign is_digit = (byte_in >= BYTE_ZERO) && (byte_in <= BYTE_NINE);
   // Within '0'..'9' the low nibble is the digit value.
   assign digit = byte_in[DIGIT_BITS-1:0];

   // Times ten as a shift-add; the top four bits flag an overflow.
   assign code_ext = {4'b0000, code_ff};
   assign code_wide = (code_ext << 3) + (code_ext << 1)
                      + {{(CODE_WIDE_BITS-DIGIT_BITS){1'b0}}, digit};
   assign code_sat = (code_wide[CODE_WIDE_BITS-1:KEY_CODE_BITS] != 4'b0000)
                     ? {KEY_CODE_BITS{1'b1}} : code_wide[KEY_CODE_BITS-1:0];

   assign mod_ext = {4'b0000, mod_ff};
   assign mod_wide = (mod_ext << 3) + (mod_ext << 1)
                     + {{(MOD_WIDE_BITS-DIGIT_BITS){1'b0}}, digit};
   assign mod_sat = (mod_wide[MOD_WIDE_BITS-1:MOD_BITS] != 4'b0000)
                    ? MOD_MAX : mod_wide[MOD_BITS-1:0];

   always_comb begin
      ctl.phase_in = phase_ff;
      ctl.done = 1'b0;
      ctl.show_key = 1'b0;
      code_in = code_ff;
      mod_in = mod_ff;
      event_in = event_ff;
      unique case (phase_ff)
         PH_SKIP: begin
            ctl.phase_in = PH_CODE;
            code_in = '0;
         end
         PH_CODE: begin
            if (is_digit) begin
               code_in = code_sat;
            end else if (byte_in == BYTE_SEMI) begin
               ctl.show_key = 1'b1;
               ctl.phase_in = PH_MOD;
            end else begin
               ctl.done = 1'b1;
            end
         end
         PH_MOD: begin
            if (is_digit) begin
               mod_in = mod_sat;
            end else if (byte_in == BYTE_COLON) begin
               ctl.phase_in = PH_EVENT;
            end
         end
         PH_EVENT: begin
            if (is_digit) begin
               event_in = digit;
            end else if (byte_in == BYTE_U) begin
               ctl.done = 1'b1;
            end
         end
         default: begin
            ctl.phase_in = (byte_in == BYTE_ESC) ? PH_SKIP : PH_WAIT;
         end
      endcase
      // A finished sequence clears everything and waits for the next escape.
      if (ctl.done) begin
         ctl.phase_in = PH_WAIT;
         code_in = '0;
         mod_in = '0;
         event_in = '0;
      end
   end

endmodule

// File: test/csi_u_key_sequence_parser_top_tb.sv
module csi_u_key_sequence_parser_top_tb;
   import csiu_pkg::*;

   localparam int KEY_BITS = KEY_CODE_BITS_DEFAULT;
   localparam int MOD_LSB = KEY_BITS;
   localparam int EV_LSB = KEY_BITS + MOD_BITS;
   localparam int PAD_LSB = EV_LSB + EVENT_BITS;
   localparam int TDATA_BITS = ((PAD_LSB + 7) / 8) * 8;
   localparam int DIR_ROWS = 28;
   localparam int RANDOM_BYTES = 650;
   localparam logic [63:0] DEC_BASE = 64'd10;
   localparam logic [KEY_BITS-1:0] CODE_MAX = '1;

   typedef struct packed {
      logic                  done;
      logic [KEY_BITS-1:0]   key;
      logic [MOD_BITS-1:0]   modifier;
      logic [EVENT_BITS-1:0] ev;
   } key_result_type;

   typedef struct packed {
      logic [7:0]     data;
      logic           drain_first;
      logic           has_exp;
      key_result_type exp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic [7:0] req_tdata = 8'h00;
   logic rsp_tready = 1'b0;
   logic req_tready;
   logic rsp_tvalid;
   logic rsp_tlast;                      // done_res
   logic [TDATA_BITS-1:0] rsp_tdata;     // key, modifier, event_kind

   stim_row_type   directed_tbl [DIR_ROWS];
   stim_row_type   byte_q [$];
   key_result_type decoded_q [$];
   stim_row_type   cur_row;

   // Shadow of the parser state.
   phase_type             prs_phase;
   logic [KEY_BITS-1:0]   code_acc;
   logic [MOD_BITS-1:0]   mod_acc;
   logic [EVENT_BITS-1:0] ev_dig;

   int errors = 0;
   int bytes_sent = 0;
   int results_seen = 0;
   int keys_done = 0;
   int burst_left = 0;
   int gap_left = 0;
   int pat_count = 0;
   logic [31:0] ready_pat = '1;

   csi_u_key_sequence_parser_top #(
      .KEY_CODE_BITS(KEY_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tlast(rsp_tlast),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic stim_row_type dir(input logic [7:0] b);
      stim_row_type r;
      r = '0;
      r.data = b;
      return r;
   endfunction

   function automatic stim_row_type chk(input logic [7:0] b, input logic d,
                                        input logic [KEY_BITS-1:0] k,
                                        input logic [MOD_BITS-1:0] m,
                                        input logic [EVENT_BITS-1:0] e);
      stim_row_type r;
      r = dir(b);
      r.has_exp = 1'b1;
      r.exp.done = d;
      r.exp.key = k;
      r.exp.modifier = m;
      r.exp.ev = e;
      return r;
   endfunction

   function automatic bit is_digit(input logic [7:0] b);
      return (b >= BYTE_ZERO) && (b <= BYTE_NINE);
   endfunction

   // Completing a sequence shows the accumulators and clears them.
   function automatic key_result_type close_sequence();
      key_result_type r;
      r.done = 1'b1;
      r.key = code_acc;
      r.modifier = mod_acc;
      r.ev = ev_dig;
      code_acc = '0;
      mod_acc = '0;
      ev_dig = '0;
      prs_phase = PH_WAIT;
      return r;
   endfunction

   function automatic key_result_type parse_byte(input logic [7:0] b);
      key_result_type r;
      logic [63:0] t;
      logic [7:0] digit;
      r = '0;
      digit = b - BYTE_ZERO;
      case (prs_phase)
         PH_SKIP: begin
            prs_phase = PH_CODE;
            code_acc = '0;
         end
         PH_CODE: begin
            if (is_digit(b)) begin
               t = 64'(code_acc) * DEC_BASE + 64'(digit);
               code_acc = (t > 64'(CODE_MAX)) ? CODE_MAX : t[KEY_BITS-1:0];
            end else if (b == BYTE_SEMI) begin
               r.key = code_acc;
               prs_phase = PH_MOD;
            end else begin
               r = close_sequence();
            end
         end
         PH_MOD: begin
            if (is_digit(b)) begin
               t = 64'(mod_acc) * DEC_BASE + 64'(digit);
               mod_acc = (t > 64'(MOD_MAX)) ? MOD_MAX : t[MOD_BITS-1:0];
            end else if (b == BYTE_COLON) begin
               prs_phase = PH_EVENT;
            end
         end
         PH_EVENT: begin
            if (is_digit(b)) begin
               ev_dig = digit[EVENT_BITS-1:0];
            end else if (b == BYTE_U) begin
               r = close_sequence();
            end
         end
         default: begin
            prs_phase = (b == BYTE_ESC) ? PH_SKIP : PH_WAIT;
         end
      endcase
      return r;
   endfunction

   function automatic logic [7:0] rand_digit();
      return BYTE_ZERO + 8'($urandom_range(0, 9));
   endfunction

   // A random byte that is neither a digit nor the given byte.
   function automatic logic [7:0] rand_stray(input logic [7:0] excl);
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (is_digit(b) || b == excl) b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   task automatic add_byte(input logic [7:0] b);
      byte_q.push_back(dir(b));
   endtask

   task automatic build_random();
      int counted;
      int kind;
      int n;
      int start;
      counted = 0;
      while (counted < RANDOM_BYTES) begin
         kind = $urandom_range(0, 9);
         start = byte_q.size();
         if (kind < 7) begin
            add_byte(BYTE_ESC);
            add_byte(8'($urandom_range(0, 255)));
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 9) : $urandom_range(0, 4);
            for (int i = 0; i < n; i++) add_byte(rand_digit());
            if ($urandom_range(0, 2) == 0) begin
               add_byte(rand_stray(BYTE_SEMI));
            end else begin
               add_byte(BYTE_SEMI);
               n = ($urandom_range(0, 5) == 0) ? 4 : $urandom_range(0, 3);
               for (int i = 0; i < n; i++) begin
                  if ($urandom_range(0, 4) == 0) add_byte(rand_stray(BYTE_COLON));
                  add_byte(rand_digit());
               end
               add_byte(BYTE_COLON);
               n = $urandom_range(0, 3);
               for (int i = 0; i < n; i++) begin
                  if ($urandom_range(0, 4) == 0) add_byte(rand_stray(BYTE_U));
                  add_byte(rand_digit());
               end
               if ($urandom_range(0, 7) == 0) add_byte(rand_stray(BYTE_U));
               add_byte(BYTE_U);
            end
         end else if (kind < 9) begin
            // Line noise between sequences; mostly ignored by the parser.
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
         end else begin
            // Sequence cut short; whatever follows ends or feeds it.
            add_byte(BYTE_ESC);
            if ($urandom_range(0, 1) == 1) add_byte(8'($urandom_range(0, 255)));
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) add_byte(rand_digit());
            if ($urandom_range(0, 1) == 1) add_byte(BYTE_SEMI);
         end
         counted += byte_q.size() - start;
      end
   endtask

   task automatic check_result();
      key_result_type e;
      results_seen++;
      if (decoded_q.size() == 0) begin
         $error("result beat with no byte pending");
         errors++;
      end else begin
         e = decoded_q.pop_front();
         if (rsp_tlast !== e.done) begin
            $error("done_res mismatch: expected %0d, actual %0d", e.done, rsp_tlast);
            errors++;
         end
         if (rsp_tdata[KEY_BITS-1:0] !== e.key) begin
            $error("key mismatch: expected %0d, actual %0d", e.key,
                   rsp_tdata[KEY_BITS-1:0]);
            errors++;
         end
         if (rsp_tdata[EV_LSB-1:MOD_LSB] !== e.modifier) begin
            $error("modifier mismatch: expected %0d, actual %0d", e.modifier,
                   rsp_tdata[EV_LSB-1:MOD_LSB]);
            errors++;
         end
         if (rsp_tdata[PAD_LSB-1:EV_LSB] !== e.ev) begin
            $error("event_kind mismatch: expected %0d, actual %0d", e.ev,
                   rsp_tdata[PAD_LSB-1:EV_LSB]);
            errors++;
         end
         if (rsp_tdata[TDATA_BITS-1:PAD_LSB] !== '0) begin
            $error("tdata padding mismatch: expected 0, actual %0h",
                   rsp_tdata[TDATA_BITS-1:PAD_LSB]);
            errors++;
         end
      end
   endtask

   // Sender, predictor and checker share one edge so the queues stay ordered.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         prs_phase = PH_WAIT;
         code_acc = '0;
         mod_acc = '0;
         ev_dig = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (req_tvalid && req_tready) begin
            key_result_type p;
            p = parse_byte(cur_row.data);
            decoded_q.push_back(cur_row.has_exp ? cur_row.exp : p);
            bytes_sent++;
            if (p.done) keys_done++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (byte_q.size() != 0 &&
                         !(byte_q[0].drain_first && decoded_q.size() != 0)) begin
               cur_row = byte_q.pop_front();
               req_tdata <= cur_row.data;
               req_tvalid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // The sink walks a 32-bit ready pattern that is redrawn whenever pat_count reaches zero.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         pat_count <= 0;
      end else begin
         if (pat_count == 0) begin
            case ($urandom_range(0, 3))
               0: ready_pat = '1;
               1: ready_pat = $urandom;
               2: ready_pat = $urandom & $urandom;
               default: ready_pat = $urandom | $urandom;
            endcase
            pat_count <= 47;
         end else begin
            pat_count <= pat_count - 1;
         end
         rsp_tready <= ready_pat[pat_count[4:0]];
      end
   end

   initial begin
      directed_tbl = '{
         chk(8'h00, 1'b0, '0, '0, '0),
         dir(BYTE_ESC), dir(8'h5B), dir(BYTE_NINE),
         chk(BYTE_U, 1'b1, KEY_BITS'(9), '0, '0),
         dir(BYTE_ESC), dir(8'h00),
         dir(BYTE_NINE), dir(BYTE_NINE), dir(BYTE_NINE), dir(BYTE_NINE),
         dir(BYTE_NINE), dir(BYTE_NINE), dir(BYTE_NINE),
         chk(8'hB0, 1'b1, CODE_MAX, '0, '0),
         dir(BYTE_ESC), dir(8'hFF), dir(8'h31),
         chk(BYTE_SEMI, 1'b0, KEY_BITS'(1), '0, '0),
         dir(8'h32), dir(8'h35), dir(8'h36), dir(8'h7A), dir(BYTE_COLON),
         dir(8'h33), dir(8'h37), dir(8'hFF),
         chk(BYTE_U, 1'b1, KEY_BITS'(1), MOD_MAX, EVENT_BITS'(7))
      };
      for (int i = 0; i < DIR_ROWS; i++) byte_q.push_back(directed_tbl[i]);
      build_random();
      byte_q[DIR_ROWS].drain_first = 1'b1;
      byte_q[(DIR_ROWS + byte_q.size()) / 2].drain_first = 1'b1;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (byte_q.size() != 0 || req_tvalid || decoded_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (decoded_q.size() != 0) begin
         $error("%0d result beats never arrived", decoded_q.size());
         errors++;
      end
      $display("Sent %0d bytes, checked %0d result beats, %0d completed key sequences.",
               bytes_sent, results_seen, keys_done);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timed out with %0d bytes unsent.", byte_q.size());
      $display("status: fail");
      $finish;
   end

endmodule
